>>> src/iss_pkg.sv
// shared types and constants of the indexed sequence store
// no dependencies; compiled first
`default_nettype none

package iss_pkg;

  localparam int unsigned ACT_W = 3;
  localparam int unsigned POS_W = 7;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CNT_W = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_INSERT_AT  = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_POP_REAR   = 3'd4,
    ACT_REMOVE_AT  = 3'd5,
    ACT_FIND       = 3'd6
  } act_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // one datapath operation per cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_START_UP,
    DP_STEP_UP,
    DP_WRITE_NEW,
    DP_START_RD,
    DP_GRAB,
    DP_STEP_DN,
    DP_START_SCAN,
    DP_STEP_SCAN,
    DP_FINISH
  } dp_op_e;

  typedef enum logic [1:0] {
    DELTA_NONE,
    DELTA_INC,
    DELTA_DEC
  } delta_e;

  typedef struct packed {
    dp_op_e  op;
    status_e status;
    delta_e  delta;
    logic    sel_rval;
    logic    sel_fidx;
  } iss_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic up_done;
    logic dn_last;
    logic next_last;
    logic match;
  } iss_flags_t;

endpackage

`default_nettype wire

>>> src/iss_if.sv
// request and response channel interfaces of the indexed sequence store
// depends on iss_pkg
`default_nettype none

interface iss_in_if import iss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, action, position, item_value, input ready);
  modport sink   (input valid, action, position, item_value, output ready);
endinterface

interface iss_out_if import iss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] result_value;
  logic [IDX_W-1:0]        found_index;
  logic [CNT_W-1:0]        entry_count;

  modport source (output valid, status, result_value, found_index, entry_count, input ready);
  modport sink   (input valid, status, result_value, found_index, entry_count, output ready);
endinterface

`default_nettype wire

>>> src/iss_ctrl.sv
// controller state machine of the indexed sequence store
// depends on iss_pkg; drives iss_dp through iss_cmd_t
`default_nettype none

module iss_ctrl import iss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ACT_W-1:0] action_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  iss_flags_t       flags_i,
  output iss_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_UP,
    S_WRITE,
    S_GRAB,
    S_DOWN,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e           state_q, state_d;
  logic [ACT_W-1:0] act_q, act_d;
  logic             out_valid_q, out_valid_d;
  status_e          fin_status_q, fin_status_d;
  delta_e           fin_delta_q, fin_delta_d;
  logic             fin_rval_q, fin_rval_d;
  logic             fin_fidx_q, fin_fidx_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    fin_status_d = fin_status_q;
    fin_delta_d  = fin_delta_q;
    fin_rval_d   = fin_rval_q;
    fin_fidx_d   = fin_fidx_q;
    cmd_o.op       = DP_NOP;
    cmd_o.status   = fin_status_q;
    cmd_o.delta    = fin_delta_q;
    cmd_o.sel_rval = fin_rval_q;
    cmd_o.sel_fidx = fin_fidx_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_CAPTURE;
          act_d    = action_i;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        fin_status_d = ST_OK;
        fin_delta_d  = DELTA_NONE;
        fin_rval_d   = 1'b0;
        fin_fidx_d   = 1'b0;
        case (act_e'(act_q))
          ACT_PUSH_FRONT, ACT_PUSH_REAR, ACT_INSERT_AT: begin
            if (flags_i.full) begin
              fin_status_d = ST_FULL;
              state_d      = S_FINISH;
            end else if ((act_e'(act_q) == ACT_INSERT_AT) && flags_i.pos_gt_cnt) begin
              fin_status_d = ST_RANGE;
              state_d      = S_FINISH;
            end else if (flags_i.pos_ge_cnt) begin
              // gap already open at the rear
              state_d = S_WRITE;
            end else begin
              cmd_o.op = DP_START_UP;
              state_d  = S_UP;
            end
          end
          ACT_POP_FRONT, ACT_POP_REAR, ACT_REMOVE_AT: begin
            if (flags_i.empty) begin
              fin_status_d = ST_EMPTY;
              state_d      = S_FINISH;
            end else if ((act_e'(act_q) == ACT_REMOVE_AT) && flags_i.pos_ge_cnt) begin
              fin_status_d = ST_RANGE;
              state_d      = S_FINISH;
            end else begin
              cmd_o.op = DP_START_RD;
              state_d  = S_GRAB;
            end
          end
          ACT_FIND: begin
            if (flags_i.empty) begin
              fin_status_d = ST_EMPTY;
              state_d      = S_FINISH;
            end else begin
              cmd_o.op = DP_START_SCAN;
              state_d  = S_SCAN;
            end
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_UP: begin
        cmd_o.op = DP_STEP_UP;
        if (flags_i.up_done) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.op     = DP_WRITE_NEW;
        fin_status_d = ST_OK;
        fin_delta_d  = DELTA_INC;
        state_d      = S_FINISH;
      end
      S_GRAB: begin
        cmd_o.op     = DP_GRAB;
        fin_status_d = ST_OK;
        fin_delta_d  = DELTA_DEC;
        fin_rval_d   = 1'b1;
        state_d      = flags_i.next_last ? S_FINISH : S_DOWN;
      end
      S_DOWN: begin
        cmd_o.op = DP_STEP_DN;
        if (flags_i.dn_last) begin
          state_d = S_FINISH;
        end
      end
      S_SCAN: begin
        if (flags_i.match) begin
          fin_status_d = ST_OK;
          fin_fidx_d   = 1'b1;
          state_d      = S_FINISH;
        end else if (flags_i.next_last) begin
          fin_status_d = ST_NOT_FOUND;
          state_d      = S_FINISH;
        end else begin
          cmd_o.op = DP_STEP_SCAN;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = DP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cmd_o.op == DP_FINISH) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      act_q        <= '0;
      out_valid_q  <= 1'b0;
      fin_status_q <= ST_OK;
      fin_delta_q  <= DELTA_NONE;
      fin_rval_q   <= 1'b0;
      fin_fidx_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      act_q        <= act_d;
      out_valid_q  <= out_valid_d;
      fin_status_q <= fin_status_d;
      fin_delta_q  <= fin_delta_d;
      fin_rval_q   <= fin_rval_d;
      fin_fidx_q   <= fin_fidx_d;
    end
  end

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CHECK))
    else $error("accepted request did not move to check");

  a_finish_presents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == DP_FINISH) |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("finished transaction not presented on response");

  a_rsp_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("response withdrawn before it was taken");

endmodule

`default_nettype wire

>>> src/iss_dp.sv
// datapath of the indexed sequence store: word memory, count, pointers, result
// depends on iss_pkg; steered by iss_ctrl through iss_cmd_t
`default_nettype none

module iss_dp import iss_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  iss_cmd_t                cmd_i,
  input  logic [ACT_W-1:0]        action_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] item_value_i,
  output iss_flags_t              flags_o,
  output logic [ST_W-1:0]         status_o,
  output logic signed [VAL_W-1:0] result_value_o,
  output logic [IDX_W-1:0]        found_index_o,
  output logic [CNT_W-1:0]        entry_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned XW = PW + 1;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  logic [VAL_W-1:0] mem_q [DEPTH];
  logic [VAL_W-1:0] rd_q, rval_q, val_q, wr_data;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             we;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    ptr_p1, ptr_p2, ptr_m1, ptr_m2, count_m1;
  logic [PW-1:0]    pos_q, cap_pos;
  logic [XW-1:0]    count_x, ptr_x, pos_x;
  logic [PW-1:0]    count_d_w, ptr_w;
  logic [ST_W-1:0]         res_status_q;
  logic signed [VAL_W-1:0] res_rval_q;
  logic [IDX_W-1:0]        res_fidx_q;
  logic [CNT_W-1:0]        res_count_q;

  assign ptr_p1   = ptr_q + CW'(1);
  assign ptr_p2   = ptr_q + CW'(2);
  assign ptr_m1   = ptr_q - CW'(1);
  assign ptr_m2   = ptr_q - CW'(2);
  assign count_m1 = count_q - CW'(1);

  assign count_x = XW'(count_q);
  assign ptr_x   = XW'(ptr_q);
  assign pos_x   = XW'(pos_q);

  assign flags_o.full       = (count_x == DEPTH_X);
  assign flags_o.empty      = (count_q == '0);
  assign flags_o.pos_gt_cnt = (pos_x > count_x);
  assign flags_o.pos_ge_cnt = (pos_x >= count_x);
  assign flags_o.up_done    = ((ptr_x - XW'(1)) == pos_x);
  assign flags_o.dn_last    = ((ptr_x + XW'(2)) >= count_x);
  assign flags_o.next_last  = ((ptr_x + XW'(1)) >= count_x);
  assign flags_o.match      = (rd_q == val_q);

  // effective index of the request
  always_comb begin
    case (act_e'(action_i))
      ACT_PUSH_FRONT, ACT_POP_FRONT: cap_pos = '0;
      ACT_PUSH_REAR:                 cap_pos = PW'(count_q);
      ACT_POP_REAR:                  cap_pos = PW'(count_m1);
      default:                       cap_pos = PW'(position_i);
    endcase
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = ptr_q[AW-1:0];
    wr_data = rd_q;
    rd_addr = ptr_q[AW-1:0];
    ptr_d   = ptr_q;
    case (cmd_i.op)
      DP_START_UP: begin
        rd_addr = count_m1[AW-1:0];
        ptr_d   = count_q;
      end
      DP_STEP_UP: begin
        we      = 1'b1;
        rd_addr = ptr_m2[AW-1:0];
        ptr_d   = ptr_m1;
      end
      DP_WRITE_NEW: begin
        we      = 1'b1;
        wr_addr = pos_q[AW-1:0];
        wr_data = val_q;
      end
      DP_START_RD: begin
        rd_addr = pos_q[AW-1:0];
        ptr_d   = pos_q[CW-1:0];
      end
      DP_GRAB: begin
        rd_addr = ptr_p1[AW-1:0];
      end
      DP_STEP_DN: begin
        we      = 1'b1;
        rd_addr = ptr_p2[AW-1:0];
        ptr_d   = ptr_p1;
      end
      DP_START_SCAN: begin
        rd_addr = '0;
        ptr_d   = '0;
      end
      DP_STEP_SCAN: begin
        rd_addr = ptr_p1[AW-1:0];
        ptr_d   = ptr_p1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.op == DP_FINISH) begin
      case (cmd_i.delta)
        DELTA_INC: count_d = count_q + CW'(1);
        DELTA_DEC: count_d = count_m1;
        default:   count_d = count_q;
      endcase
    end
  end

  assign count_d_w = PW'(count_d);
  assign ptr_w     = PW'(ptr_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.op == DP_CAPTURE) begin
      pos_q <= cap_pos;
      val_q <= item_value_i;
    end
    if (cmd_i.op == DP_GRAB) begin
      rval_q <= rd_q;
    end
    if (cmd_i.op == DP_FINISH) begin
      res_status_q <= cmd_i.status;
      res_rval_q   <= cmd_i.sel_rval ? rval_q : '0;
      res_fidx_q   <= cmd_i.sel_fidx ? ptr_w[IDX_W-1:0] : '0;
      res_count_q  <= count_d_w[CNT_W-1:0];
    end
  end

  assign status_o       = res_status_q;
  assign result_value_o = res_rval_q;
  assign found_index_o  = res_fidx_q;
  assign entry_count_o  = res_count_q;

  a_inc_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.op == DP_FINISH) && (cmd_i.delta == DELTA_INC)) |-> (count_x < DEPTH_X))
    else $error("count raised while full");

  a_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.op == DP_FINISH) && (cmd_i.delta == DELTA_DEC)) |-> (count_q != '0))
    else $error("count lowered while empty");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.op == DP_STEP_UP) || (cmd_i.op == DP_WRITE_NEW) || (cmd_i.op == DP_STEP_DN))
      |-> (XW'(wr_addr) <= count_x))
    else $error("memory written beyond the stored words");

endmodule

`default_nettype wire

>>> src/indexed_sequence_store_top.sv
// indexed sequence store: an ordered list of up to DEPTH signed words with a count;
// each request transaction yields one response transaction. Failed or unused actions
// and a push or pop at an end that needs no shifting move no stored words; insert
// at index p shifts the stored words from p upward, remove at p shifts those above p,
// and find scans from index 0 until a match or the last stored word. A finished request
// waits while the previous response is still held. The word memory, with one read and
// one write port, moves or compares one stored word per cycle. One request is worked
// at a time; a new one is accepted while the previous response still waits to be taken.
// depends on iss_pkg, iss_if, iss_ctrl, iss_dp
`default_nettype none

module indexed_sequence_store_top import iss_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input logic      clk_i,
  input logic      rst_ni,
  iss_in_if.sink   req_i,
  iss_out_if.source rsp_o
);

  // command and status between the state machine and the datapath
  iss_cmd_t   cmd;
  iss_flags_t flags;

  // controller: accepts a request transaction when idle, sequences the shift,
  // scan or single write, then presents the response once the slot is free
  iss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .action_i    (req_i.action),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  // datapath: word memory with registered read, the count, the walking pointer
  // and the response register that holds a result until it is taken
  iss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (req_i.action),
    .position_i     (req_i.position),
    .item_value_i   (req_i.item_value),
    .flags_o        (flags),
    .status_o       (rsp_o.status),
    .result_value_o (rsp_o.result_value),
    .found_index_o  (rsp_o.found_index),
    .entry_count_o  (rsp_o.entry_count)
  );

endmodule

`default_nettype wire
